@@ design/trig_velocity_displacement_assert.svh @@
// Assertion macros shared by the checker of the velocity displacement block.
`ifndef TRIG_VELOCITY_DISPLACEMENT_ASSERT_SVH
`define TRIG_VELOCITY_DISPLACEMENT_ASSERT_SVH

// The consequent must hold in the cycle after the antecedent.
`define TVD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("tvd check failed");

// The consequent must hold in the same cycle as the antecedent.
`define TVD_ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("tvd check failed");

`endif

@@ design/tvd_pkg.sv @@
// ----------------------------------------------------------------------------
// tvd_pkg
// Types, widths and constants of the trigonometric velocity displacement.
// ----------------------------------------------------------------------------
package tvd_pkg;

  localparam int unsigned TRIG_STAGES_DEF = 16;
  localparam int unsigned TRIG_STAGES_MAX = 24;

  localparam int unsigned COORD_W = 18;
  localparam int unsigned VEL_W   = 19;
  localparam int unsigned FREQ_W  = 22;
  localparam int unsigned AMP_W   = 21;
  localparam int unsigned MODE_W  = 4;
  localparam int unsigned FS_W    = FREQ_W + 1;
  localparam int unsigned ANG_W   = FS_W + COORD_W;
  localparam int unsigned PH_W    = 32;
  localparam int unsigned TRIG_W  = 33;
  localparam int unsigned Z_W     = 34;
  localparam int unsigned TAN_QB  = 33;
  localparam int unsigned TAN_W   = TAN_QB + 1;

  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 22;

  localparam int unsigned IN_DATA_W  = 80;
  localparam int unsigned OUT_DATA_W = 40;

  // round(2^39 / pi): a Q24 angle times this gives the phase in the upper word.
  localparam int unsigned      RTT_W       = 38;
  localparam int unsigned      RTT_SPLIT   = 19;
  localparam logic [RTT_W-1:0] RAD_TO_TURN = 38'd174992710547;

  localparam logic signed [TRIG_W-1:0] CORDIC_X0    = 33'sd652032874;
  localparam logic signed [Z_W-1:0]    QUARTER_TURN = 34'sd1073741824;
  localparam logic signed [Z_W-1:0]    HALF_TURN    = 34'sd2147483648;
  localparam logic [TAN_QB-1:0]        TAN_LIMIT    = 33'h1_0000_0000;

  localparam logic signed [VEL_W+1:0] VEL_MAX = 21'sd262143;
  localparam logic signed [VEL_W+1:0] VEL_MIN = -21'sd262144;

  localparam logic [29:0] ATAN_TURNS [TRIG_STAGES_MAX] = '{
    30'd536870912, 30'd316933406, 30'd167458907, 30'd85004756, 30'd42667331,
    30'd21354465, 30'd10679838, 30'd5340245, 30'd2670163, 30'd1335087,
    30'd667544, 30'd333772, 30'd166886, 30'd83443, 30'd41722, 30'd20861,
    30'd10430, 30'd5215, 30'd2608, 30'd1304, 30'd652, 30'd326, 30'd163, 30'd81
  };

  localparam logic [CFG_IDX_W-1:0] REG_EFFECT_MODE  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_REVERSE_FREQ = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_FREQ_X       = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_FREQ_Y       = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_AMP_X        = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_AMP_Y        = 3'd5;

  localparam logic [FREQ_W-1:0] FREQ_RESET = 22'd2560;
  localparam logic [AMP_W-1:0]  AMP_RESET  = 21'd139810;

  typedef enum logic [MODE_W-1:0] {
    MODE_NONE     = 4'd0,
    MODE_SIN_RECT = 4'd1,
    MODE_COS_RECT = 4'd2,
    MODE_SIN_CURL = 4'd3,
    MODE_COS_CURL = 4'd4,
    MODE_SINCOS   = 4'd5,
    MODE_COSSIN   = 4'd6,
    MODE_SINTAN   = 4'd7,
    MODE_COSTAN   = 4'd8,
    MODE_SINOFCOS = 4'd9,
    MODE_COSOFSIN = 4'd10
  } effect_mode_e;

  // What the first CORDIC result turns into before the second one.
  typedef enum logic [1:0] {
    FIRST_DIRECT = 2'd0,
    FIRST_TAN    = 2'd1,
    FIRST_PI_SIN = 2'd2,
    FIRST_PI_COS = 2'd3
  } first_op_e;

  typedef struct packed {
    first_op_e        first_op;
    logic             final_sin;
    logic             active;
    logic [AMP_W-1:0] amp;
  } lane_ctrl_t;

endpackage

@@ design/trig_velocity_displacement.sv @@
// ----------------------------------------------------------------------------
// trig_velocity_displacement
// Adds a sin, cos or tan based displacement to a point's velocity.
// ----------------------------------------------------------------------------
// The block takes one point per clock and returns one result per clock, in
// order, while no stall holds the output. Each axis runs two chains of
// TRIG_STAGES CORDIC iterations, a 33-step tan divider, four multiplier
// stages and the registers around them, all in one pipeline that every item
// crosses regardless of the effect mode. The pipeline moves whenever the
// output register is empty or being taken, so a stall downstream holds the
// input ready low. Configuration is written while idle: a rule for the user,
// which the block itself does not enforce.
module trig_velocity_displacement #(
  parameter int unsigned TRIG_STAGES = tvd_pkg::TRIG_STAGES_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [tvd_pkg::CFG_IDX_W-1:0]       cfg_idx_i,
  input  logic [tvd_pkg::CFG_DATA_W-1:0]      cfg_data_i,
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  // coord_x[17:0], coord_y[35:18], vel_x[54:36], vel_y[73:55], zero[79:74]
  input  logic [tvd_pkg::IN_DATA_W-1:0]       s_axis_tdata,
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  // new_vel_x[18:0], new_vel_y[37:19], zero[39:38]
  output logic [tvd_pkg::OUT_DATA_W-1:0]      m_axis_tdata
);

  localparam int unsigned CW = tvd_pkg::COORD_W;
  localparam int unsigned VW = tvd_pkg::VEL_W;
  localparam int unsigned FW = tvd_pkg::FREQ_W;
  localparam int unsigned AW = tvd_pkg::AMP_W;

  logic [tvd_pkg::MODE_W-1:0] mode_q;
  logic                       rev_q;
  logic [FW-1:0]              fx_q, fy_q;
  logic [AW-1:0]              ax_q, ay_q;

  logic signed [tvd_pkg::FS_W-1:0] fx_s, fy_s;
  logic signed [tvd_pkg::FS_W-1:0] lx_freq, ly_freq;
  logic                            lx_use_y, ly_use_y;
  tvd_pkg::lane_ctrl_t             lx_ctrl, ly_ctrl;

  logic signed [CW-1:0] coord_x, coord_y;
  logic signed [VW-1:0] vel_x, vel_y;

  logic                 en;
  logic                 lx_vld, ly_vld;
  logic [VW-1:0]        lx_vel, ly_vel;
  logic                 out_vld_q;
  logic [2*VW-1:0]      out_data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= tvd_pkg::MODE_NONE;
      rev_q  <= 1'b0;
      fx_q   <= tvd_pkg::FREQ_RESET;
      fy_q   <= tvd_pkg::FREQ_RESET;
      ax_q   <= tvd_pkg::AMP_RESET;
      ay_q   <= tvd_pkg::AMP_RESET;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        tvd_pkg::REG_EFFECT_MODE:  mode_q <= cfg_data_i[tvd_pkg::MODE_W-1:0];
        tvd_pkg::REG_REVERSE_FREQ: rev_q  <= cfg_data_i[0];
        tvd_pkg::REG_FREQ_X:       fx_q   <= cfg_data_i[FW-1:0];
        tvd_pkg::REG_FREQ_Y:       fy_q   <= cfg_data_i[FW-1:0];
        tvd_pkg::REG_AMP_X:        ax_q   <= cfg_data_i[AW-1:0];
        tvd_pkg::REG_AMP_Y:        ay_q   <= cfg_data_i[AW-1:0];
        default: ;
      endcase
    end
  end

  assign fx_s = rev_q ? -$signed({1'b0, fx_q}) : $signed({1'b0, fx_q});
  assign fy_s = rev_q ? -$signed({1'b0, fy_q}) : $signed({1'b0, fy_q});

  // Per-axis routing of frequency, coordinate and trig functions by mode.
  always_comb begin
    lx_ctrl.amp       = ax_q;
    ly_ctrl.amp       = ay_q;
    lx_ctrl.active    = 1'b1;
    ly_ctrl.active    = 1'b1;
    lx_ctrl.first_op  = tvd_pkg::FIRST_DIRECT;
    ly_ctrl.first_op  = tvd_pkg::FIRST_DIRECT;
    lx_ctrl.final_sin = 1'b1;
    ly_ctrl.final_sin = 1'b1;
    lx_freq  = fy_s;
    lx_use_y = 1'b1;
    ly_freq  = fx_s;
    ly_use_y = 1'b0;
    case (tvd_pkg::effect_mode_e'(mode_q))
      tvd_pkg::MODE_SIN_RECT: begin
        lx_freq = fx_s; lx_use_y = 1'b0; ly_freq = fy_s; ly_use_y = 1'b1;
      end
      tvd_pkg::MODE_COS_RECT: begin
        lx_freq = fx_s; lx_use_y = 1'b0; ly_freq = fy_s; ly_use_y = 1'b1;
        lx_ctrl.final_sin = 1'b0; ly_ctrl.final_sin = 1'b0;
      end
      tvd_pkg::MODE_SIN_CURL: ;
      tvd_pkg::MODE_COS_CURL: begin
        lx_ctrl.final_sin = 1'b0; ly_ctrl.final_sin = 1'b0;
      end
      tvd_pkg::MODE_SINCOS: begin
        lx_freq = fx_s; ly_freq = fy_s; ly_ctrl.final_sin = 1'b0;
      end
      tvd_pkg::MODE_COSSIN: begin
        lx_ctrl.final_sin = 1'b0;
      end
      tvd_pkg::MODE_SINTAN: begin
        lx_ctrl.first_op = tvd_pkg::FIRST_TAN; ly_ctrl.first_op = tvd_pkg::FIRST_TAN;
        ly_ctrl.final_sin = 1'b0;
      end
      tvd_pkg::MODE_COSTAN: begin
        lx_ctrl.first_op = tvd_pkg::FIRST_TAN; ly_ctrl.first_op = tvd_pkg::FIRST_TAN;
        lx_ctrl.final_sin = 1'b0;
      end
      tvd_pkg::MODE_SINOFCOS: begin
        lx_ctrl.first_op = tvd_pkg::FIRST_PI_COS; ly_ctrl.first_op = tvd_pkg::FIRST_PI_SIN;
        ly_ctrl.final_sin = 1'b0;
      end
      tvd_pkg::MODE_COSOFSIN: begin
        lx_ctrl.first_op = tvd_pkg::FIRST_PI_SIN; ly_ctrl.first_op = tvd_pkg::FIRST_PI_COS;
        lx_ctrl.final_sin = 1'b0;
      end
      default: begin
        lx_ctrl.active = 1'b0; ly_ctrl.active = 1'b0;
      end
    endcase
  end

  assign coord_x = s_axis_tdata[CW-1:0];
  assign coord_y = s_axis_tdata[2*CW-1:CW];
  assign vel_x   = s_axis_tdata[2*CW+VW-1:2*CW];
  assign vel_y   = s_axis_tdata[2*CW+2*VW-1:2*CW+VW];

  assign en            = !out_vld_q || m_axis_tready;
  assign s_axis_tready = en;

  tvd_lane #(.TRIG_STAGES(TRIG_STAGES)) u_lane_x (
    .clk_i, .rst_ni, .en_i (en), .ctrl_i (lx_ctrl),
    .valid_i (s_axis_tvalid), .freq_i (lx_freq),
    .coord_i (lx_use_y ? coord_y : coord_x), .vel_i (vel_x),
    .valid_o (lx_vld), .vel_o (lx_vel)
  );

  tvd_lane #(.TRIG_STAGES(TRIG_STAGES)) u_lane_y (
    .clk_i, .rst_ni, .en_i (en), .ctrl_i (ly_ctrl),
    .valid_i (s_axis_tvalid), .freq_i (ly_freq),
    .coord_i (ly_use_y ? coord_y : coord_x), .vel_i (vel_y),
    .valid_o (ly_vld), .vel_o (ly_vel)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (en) begin
      out_vld_q <= lx_vld & ly_vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      out_data_q <= {ly_vel, lx_vel};
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {{(tvd_pkg::OUT_DATA_W - 2*VW){1'b0}}, out_data_q};

endmodule

@@ design/tvd_phase.sv @@
// ----------------------------------------------------------------------------
// tvd_phase
// Turns a Q24 angle in radians into a 32-bit phase, in two pipeline stages.
// ----------------------------------------------------------------------------
module tvd_phase #(
  parameter int unsigned SIDE_W = 1
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              en_i,
  input  logic                              valid_i,
  input  logic signed [tvd_pkg::ANG_W-1:0]  angle_i,
  input  logic [SIDE_W-1:0]                 side_i,
  output logic                              valid_o,
  output logic [tvd_pkg::PH_W-1:0]          phase_o,
  output logic [SIDE_W-1:0]                 side_o
);

  localparam int unsigned KL_W = tvd_pkg::RTT_SPLIT;
  localparam int unsigned KH_W = tvd_pkg::RTT_W - tvd_pkg::RTT_SPLIT;
  localparam int unsigned LO_W = tvd_pkg::ANG_W + KL_W + 1;
  localparam int unsigned HI_W = tvd_pkg::ANG_W + KH_W + 1;

  localparam logic signed [KL_W:0] K_LO = {1'b0, tvd_pkg::RAD_TO_TURN[KL_W-1:0]};
  localparam logic signed [KH_W:0] K_HI = {1'b0, tvd_pkg::RAD_TO_TURN[tvd_pkg::RTT_W-1:KL_W]};

  logic [1:0]              vld_q;
  logic signed [LO_W-1:0]  lo_q;
  logic signed [HI_W-1:0]  hi_q;
  logic [SIDE_W-1:0]       side1_q, side2_q;
  logic [tvd_pkg::PH_W-1:0] phase_q;
  logic signed [63:0]      sum;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[0], valid_i};
    end
  end

  // The product is only needed modulo 2^64, so the constant is split in two.
  assign sum = 64'(lo_q) + (64'(hi_q) <<< KL_W);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      lo_q    <= angle_i * K_LO;
      hi_q    <= angle_i * K_HI;
      side1_q <= side_i;
      phase_q <= sum[63:32];
      side2_q <= side1_q;
    end
  end

  assign valid_o = vld_q[1];
  assign phase_o = phase_q;
  assign side_o  = side2_q;

endmodule

@@ design/tvd_cordic.sv @@
// ----------------------------------------------------------------------------
// tvd_cordic
// Pipelined rotation-mode CORDIC: one iteration per stage, Q30 sin and cos.
// ----------------------------------------------------------------------------
module tvd_cordic #(
  parameter int unsigned STAGES = tvd_pkg::TRIG_STAGES_DEF,
  parameter int unsigned SIDE_W = 1
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              en_i,
  input  logic                              valid_i,
  input  logic [tvd_pkg::PH_W-1:0]          phase_i,
  input  logic [SIDE_W-1:0]                 side_i,
  output logic                              valid_o,
  output logic signed [tvd_pkg::TRIG_W-1:0] sin_o,
  output logic signed [tvd_pkg::TRIG_W-1:0] cos_o,
  output logic [SIDE_W-1:0]                 side_o
);

  localparam int unsigned TW = tvd_pkg::TRIG_W;
  localparam int unsigned ZW = tvd_pkg::Z_W;

  logic [STAGES+1:0]        vld_q;
  logic signed [TW-1:0]     x_q [STAGES+1];
  logic signed [TW-1:0]     y_q [STAGES+1];
  logic signed [ZW-1:0]     z_q [STAGES+1];
  logic [STAGES:0]          flip_q;
  logic [SIDE_W-1:0]        side_q [STAGES+2];
  logic signed [TW-1:0]     sin_q, cos_q;
  logic signed [ZW-1:0]     z_in, z_fold;
  logic                     flip;

  // Fold the phase into the right half-plane; the result is negated later.
  always_comb begin
    z_in   = ZW'($signed(phase_i));
    z_fold = z_in;
    flip   = 1'b0;
    if (z_in > tvd_pkg::QUARTER_TURN) begin
      z_fold = z_in - tvd_pkg::HALF_TURN;
      flip   = 1'b1;
    end else if (z_in < -tvd_pkg::QUARTER_TURN) begin
      z_fold = z_in + tvd_pkg::HALF_TURN;
      flip   = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[STAGES:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      x_q[0]    <= tvd_pkg::CORDIC_X0;
      y_q[0]    <= '0;
      z_q[0]    <= z_fold;
      flip_q[0] <= flip;
      side_q[0] <= side_i;
    end
  end

  for (genvar i = 0; i < STAGES; i++) begin : g_iter
    localparam logic signed [ZW-1:0] ATAN_I = ZW'(tvd_pkg::ATAN_TURNS[i]);
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        if (!z_q[i][ZW-1]) begin
          x_q[i+1] <= x_q[i] - (y_q[i] >>> i);
          y_q[i+1] <= y_q[i] + (x_q[i] >>> i);
          z_q[i+1] <= z_q[i] - ATAN_I;
        end else begin
          x_q[i+1] <= x_q[i] + (y_q[i] >>> i);
          y_q[i+1] <= y_q[i] - (x_q[i] >>> i);
          z_q[i+1] <= z_q[i] + ATAN_I;
        end
        flip_q[i+1] <= flip_q[i];
        side_q[i+1] <= side_q[i];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sin_q <= flip_q[STAGES] ? -y_q[STAGES] : y_q[STAGES];
      cos_q <= flip_q[STAGES] ? -x_q[STAGES] : x_q[STAGES];
      side_q[STAGES+1] <= side_q[STAGES];
    end
  end

  assign valid_o = vld_q[STAGES+1];
  assign sin_o   = sin_q;
  assign cos_o   = cos_q;
  assign side_o  = side_q[STAGES+1];

endmodule

@@ design/tvd_tan.sv @@
// ----------------------------------------------------------------------------
// tvd_tan
// Pipelined restoring divider: |s| * 2^24 / |c| with saturation at 256.
// ----------------------------------------------------------------------------
module tvd_tan #(
  parameter int unsigned SIDE_W = 1
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              en_i,
  input  logic                              valid_i,
  input  logic signed [tvd_pkg::TRIG_W-1:0] sin_i,
  input  logic signed [tvd_pkg::TRIG_W-1:0] cos_i,
  input  logic [SIDE_W-1:0]                 side_i,
  output logic                              valid_o,
  output logic signed [tvd_pkg::TAN_W-1:0]  tan_o,
  output logic [SIDE_W-1:0]                 side_o
);

  localparam int unsigned QB    = tvd_pkg::TAN_QB;
  localparam int unsigned TW    = tvd_pkg::TRIG_W;
  localparam int unsigned MW    = TW - 1;
  localparam int unsigned NUM_W = MW + 24;
  localparam int unsigned CMP_W = MW + QB;

  logic [QB+1:0]       vld_q;
  logic [NUM_W-1:0]    rem_q  [QB+1];
  logic [MW-1:0]       den_q  [QB+1];
  logic [QB-1:0]       quo_q  [QB+1];
  logic [QB:0]         ovf_q, neg_q;
  logic [SIDE_W-1:0]   side_q [QB+2];
  logic signed [tvd_pkg::TAN_W-1:0] tan_q;
  logic [TW-1:0]       s_abs, c_abs;
  logic [QB-1:0]       mag;

  assign s_abs = sin_i[TW-1] ? TW'(-sin_i) : TW'(sin_i);
  assign c_abs = cos_i[TW-1] ? TW'(-cos_i) : TW'(cos_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[QB:0], valid_i};
    end
  end

  // A quotient of 2^33 or more is caught up front, so 33 steps suffice.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q[0]  <= {s_abs[MW-1:0], 24'd0};
      den_q[0]  <= c_abs[MW-1:0];
      quo_q[0]  <= '0;
      ovf_q[0]  <= (s_abs[MW-1:0] >> 9) >= c_abs[MW-1:0];
      neg_q[0]  <= sin_i[TW-1] ^ cos_i[TW-1];
      side_q[0] <= side_i;
    end
  end

  for (genvar j = 0; j < QB; j++) begin : g_step
    localparam int unsigned K = QB - 1 - j;
    logic [CMP_W-1:0] sub;
    assign sub = CMP_W'(den_q[j]) << K;
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        if (CMP_W'(rem_q[j]) >= sub) begin
          rem_q[j+1] <= rem_q[j] - sub[NUM_W-1:0];
          quo_q[j+1] <= quo_q[j] | (QB'(1) << K);
        end else begin
          rem_q[j+1] <= rem_q[j];
          quo_q[j+1] <= quo_q[j];
        end
        den_q[j+1]  <= den_q[j];
        ovf_q[j+1]  <= ovf_q[j];
        neg_q[j+1]  <= neg_q[j];
        side_q[j+1] <= side_q[j];
      end
    end
  end

  assign mag = (ovf_q[QB] || quo_q[QB] > tvd_pkg::TAN_LIMIT) ? tvd_pkg::TAN_LIMIT : quo_q[QB];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      tan_q      <= neg_q[QB] ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
      side_q[QB+1] <= side_q[QB];
    end
  end

  assign valid_o = vld_q[QB+1];
  assign tan_o   = tan_q;
  assign side_o  = side_q[QB+1];

endmodule

@@ design/tvd_lane.sv @@
// ----------------------------------------------------------------------------
// tvd_lane
// One output axis: phase, first CORDIC, tan, second CORDIC, scale, saturate.
// ----------------------------------------------------------------------------
module tvd_lane #(
  parameter int unsigned TRIG_STAGES = tvd_pkg::TRIG_STAGES_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                en_i,
  input  tvd_pkg::lane_ctrl_t                 ctrl_i,
  input  logic                                valid_i,
  input  logic signed [tvd_pkg::FS_W-1:0]     freq_i,
  input  logic signed [tvd_pkg::COORD_W-1:0]  coord_i,
  input  logic signed [tvd_pkg::VEL_W-1:0]    vel_i,
  output logic                                valid_o,
  output logic [tvd_pkg::VEL_W-1:0]           vel_o
);

  localparam int unsigned VW  = tvd_pkg::VEL_W;
  localparam int unsigned TW  = tvd_pkg::TRIG_W;
  localparam int unsigned PW  = tvd_pkg::PH_W;
  localparam int unsigned SW1 = PW + VW;
  localparam int unsigned SW2 = PW + 2 * TW + VW;
  localparam int unsigned PRW = TW + tvd_pkg::AMP_W + 1;

  logic                             ang_vld_q;
  logic signed [tvd_pkg::ANG_W-1:0] ang_q;
  logic [VW-1:0]                    ang_vel_q;

  logic                  p1_vld;
  logic [PW-1:0]         p1_phase;
  logic [VW-1:0]         p1_vel;

  logic                  c1_vld;
  logic signed [TW-1:0]  c1_sin, c1_cos;
  logic [SW1-1:0]        c1_side;

  logic                  t_vld;
  logic signed [tvd_pkg::TAN_W-1:0] t_val;
  logic [SW2-1:0]        t_side;

  logic                  p2_vld;
  logic [PW-1:0]         p2_phase;
  logic [SW2-1:0]        p2_side;

  logic [PW-1:0]         ph1;
  logic signed [TW-1:0]  s1, c1;
  logic [VW-1:0]         vel2;
  logic [PW-1:0]         ph2;

  logic                  c2_vld;
  logic signed [TW-1:0]  c2_sin, c2_cos;
  logic [VW-1:0]         c2_vel;

  logic                  sc_vld_q;
  logic signed [PRW-1:0] prod_q;
  logic [VW-1:0]         sc_vel_q;
  logic signed [PRW-1:0] rounded;
  logic signed [VW+1:0]  disp, total;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ang_vld_q <= 1'b0;
      sc_vld_q  <= 1'b0;
    end else if (en_i) begin
      ang_vld_q <= valid_i;
      sc_vld_q  <= c2_vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      ang_q     <= freq_i * coord_i;
      ang_vel_q <= vel_i;
    end
  end

  tvd_phase #(.SIDE_W(VW)) u_phase1 (
    .clk_i, .rst_ni, .en_i,
    .valid_i (ang_vld_q), .angle_i (ang_q), .side_i (ang_vel_q),
    .valid_o (p1_vld), .phase_o (p1_phase), .side_o (p1_vel)
  );

  tvd_cordic #(.STAGES(TRIG_STAGES), .SIDE_W(SW1)) u_cordic1 (
    .clk_i, .rst_ni, .en_i,
    .valid_i (p1_vld), .phase_i (p1_phase), .side_i ({p1_phase, p1_vel}),
    .valid_o (c1_vld), .sin_o (c1_sin), .cos_o (c1_cos), .side_o (c1_side)
  );

  tvd_tan #(.SIDE_W(SW2)) u_tan (
    .clk_i, .rst_ni, .en_i,
    .valid_i (c1_vld), .sin_i (c1_sin), .cos_i (c1_cos),
    .side_i  ({c1_side[SW1-1:VW], c1_sin, c1_cos, c1_side[VW-1:0]}),
    .valid_o (t_vld), .tan_o (t_val), .side_o (t_side)
  );

  tvd_phase #(.SIDE_W(SW2)) u_phase2 (
    .clk_i, .rst_ni, .en_i,
    .valid_i (t_vld), .angle_i (tvd_pkg::ANG_W'(t_val)), .side_i (t_side),
    .valid_o (p2_vld), .phase_o (p2_phase), .side_o (p2_side)
  );

  assign ph1  = p2_side[SW2-1 -: PW];
  assign s1   = p2_side[VW + 2*TW - 1 -: TW];
  assign c1   = p2_side[VW + TW - 1 -: TW];
  assign vel2 = p2_side[VW-1:0];

  // Pi times a Q30 value is exactly twice it as a phase. Direct modes rerun the
  // first phase, which gives the same sin and cos again.
  always_comb begin
    unique case (ctrl_i.first_op)
      tvd_pkg::FIRST_TAN:    ph2 = p2_phase;
      tvd_pkg::FIRST_PI_SIN: ph2 = {s1[PW-2:0], 1'b0};
      tvd_pkg::FIRST_PI_COS: ph2 = {c1[PW-2:0], 1'b0};
      default:               ph2 = ph1;
    endcase
  end

  tvd_cordic #(.STAGES(TRIG_STAGES), .SIDE_W(VW)) u_cordic2 (
    .clk_i, .rst_ni, .en_i,
    .valid_i (p2_vld), .phase_i (ph2), .side_i (vel2),
    .valid_o (c2_vld), .sin_o (c2_sin), .cos_o (c2_cos), .side_o (c2_vel)
  );

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      prod_q   <= (ctrl_i.final_sin ? c2_sin : c2_cos) * $signed({1'b0, ctrl_i.amp});
      sc_vel_q <= c2_vel;
    end
  end

  assign rounded = (prod_q + $signed(PRW'(1) << 37)) >>> 38;
  assign disp    = ctrl_i.active ? rounded[VW+1:0] : '0;
  assign total   = (VW+2)'($signed(sc_vel_q)) + disp;

  always_comb begin
    if (total > tvd_pkg::VEL_MAX) begin
      vel_o = tvd_pkg::VEL_MAX[VW-1:0];
    end else if (total < tvd_pkg::VEL_MIN) begin
      vel_o = tvd_pkg::VEL_MIN[VW-1:0];
    end else begin
      vel_o = total[VW-1:0];
    end
  end

  assign valid_o = sc_vld_q;

endmodule

@@ design/tvd_chk.sv @@
// ----------------------------------------------------------------------------
// tvd_chk
// Port-level checks of the velocity displacement block's stream behavior.
// ----------------------------------------------------------------------------
`include "trig_velocity_displacement_assert.svh"

module tvd_chk (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           s_axis_tready,
  input logic                           m_axis_tvalid,
  input logic                           m_axis_tready,
  input logic [tvd_pkg::OUT_DATA_W-1:0] m_axis_tdata
);

  // A result that is not taken stays offered unchanged.
  `TVD_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata))

  // A blocked output register freezes the pipeline, so no input is taken.
  `TVD_ASSERT_SAME(a_stall_back, clk_i, rst_ni, m_axis_tvalid && !m_axis_tready, !s_axis_tready)

  // An empty output register never holds the input back.
  `TVD_ASSERT_SAME(a_empty_ready, clk_i, rst_ni, !m_axis_tvalid, s_axis_tready)

  // Reset leaves no transaction behind in the output register.
  `TVD_ASSERT_NEXT(a_reset_empty, clk_i, 1'b1, !rst_ni, !m_axis_tvalid)

endmodule

bind trig_velocity_displacement tvd_chk u_tvd_chk (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

@@ dv/trig_velocity_displacement_tb.sv @@
// ----------------------------------------------------------------------------
// trig_velocity_displacement_tb
// Streams points through the velocity displacement block under changing
// effect modes, frequencies and amplitudes, with random flow control, and
// checks every output transaction against a bit-true model of the arithmetic.
// ----------------------------------------------------------------------------
module trig_velocity_displacement_tb;
  import tvd_pkg::*;

  localparam int unsigned PIPE_LAT    = 2 * TRIG_STAGES_DEF + 46;
  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int unsigned HOLD_CYCLES = 300;
  localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED = 3'd6;
  localparam logic [MODE_W-1:0] MODE_UNUSED_LO = 4'd11;
  localparam logic [MODE_W-1:0] MODE_UNUSED_HI = 4'd15;

  typedef struct {
    logic [VEL_W-1:0] vx;
    logic [VEL_W-1:0] vy;
  } vel_pair_t;

  typedef struct {
    logic [CFG_DATA_W-1:0] mode;
    logic [CFG_DATA_W-1:0] rev;
    logic [CFG_DATA_W-1:0] fx;
    logic [CFG_DATA_W-1:0] fy;
    logic [CFG_DATA_W-1:0] ax;
    logic [CFG_DATA_W-1:0] ay;
  } disp_cfg_t;

  class displacement_scoreboard;
    logic [MODE_W-1:0] mode;
    logic              rev;
    logic [FREQ_W-1:0] fx, fy;
    logic [AMP_W-1:0]  ax, ay;
    vel_pair_t         pending_q[$];
    int unsigned       mismatches;
    int unsigned       checked;

    function new();
      mode = MODE_NONE;
      rev  = 1'b0;
      fx   = FREQ_RESET;
      fy   = FREQ_RESET;
      ax   = AMP_RESET;
      ay   = AMP_RESET;
      mismatches = 0;
      checked = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
      case (idx)
        REG_EFFECT_MODE:  mode = val[MODE_W-1:0];
        REG_REVERSE_FREQ: rev  = val[0];
        REG_FREQ_X:       fx   = val[FREQ_W-1:0];
        REG_FREQ_Y:       fy   = val[FREQ_W-1:0];
        REG_AMP_X:        ax   = val[AMP_W-1:0];
        REG_AMP_Y:        ay   = val[AMP_W-1:0];
        default: ;
      endcase
    endfunction

    // A Q24 angle in radians becomes a phase in units of 2^-32 turn.
    function logic [31:0] to_phase(longint q24);
      logic [63:0] p;
      p = q24 * 64'd174992710547;
      return p[63:32];
    endfunction

    function void rotate(logic [31:0] ph, output longint s, output longint c);
      longint z, x, y, nx;
      bit     flip;
      z = longint'($signed(ph));
      x = longint'(CORDIC_X0);
      y = 0;
      flip = 1'b0;
      if (z > QUARTER_TURN) begin
        z -= HALF_TURN;
        flip = 1'b1;
      end else if (z < -longint'(QUARTER_TURN)) begin
        z += HALF_TURN;
        flip = 1'b1;
      end
      for (int i = 0; i < TRIG_STAGES_DEF; i++) begin
        if (z >= 0) begin
          nx = x - (y >>> i);
          y  = y + (x >>> i);
          z -= longint'(ATAN_TURNS[i]);
        end else begin
          nx = x + (y >>> i);
          y  = y - (x >>> i);
          z += longint'(ATAN_TURNS[i]);
        end
        x = nx;
      end
      s = flip ? -y : y;
      c = flip ? -x : x;
    endfunction

    function longint sin_of(logic [31:0] ph);
      longint s, c;
      rotate(ph, s, c);
      return s;
    endfunction

    function longint cos_of(logic [31:0] ph);
      longint s, c;
      rotate(ph, s, c);
      return c;
    endfunction

    function logic [31:0] tan_of(logic [31:0] ph);
      longint s, c, mag;
      logic [63:0] num, den, q;
      rotate(ph, s, c);
      num = 64'(s < 0 ? -s : s) << 24;
      den = 64'(c < 0 ? -c : c);
      if (den == 0) begin
        mag = longint'(TAN_LIMIT);
      end else begin
        q = num / den;
        mag = (q > 64'(TAN_LIMIT)) ? longint'(TAN_LIMIT) : longint'(q);
      end
      if ((s < 0) != (c < 0)) mag = -mag;
      return to_phase(mag);
    endfunction

    function logic [31:0] pi_of(longint q30);
      logic [63:0] p;
      p = q30 * 2;
      return p[31:0];
    endfunction

    function logic [VEL_W-1:0] add_sat(longint vel, longint trig, logic [AMP_W-1:0] amp,
                                       bit active);
      longint sum;
      sum = vel;
      if (active) sum += (trig * longint'(amp) + (64'sd1 <<< 37)) >>> 38;
      if (sum > VEL_MAX) sum = VEL_MAX;
      if (sum < VEL_MIN) sum = VEL_MIN;
      return sum[VEL_W-1:0];
    endfunction

    function void note_input(logic [IN_DATA_W-1:0] d);
      longint cx, cy, vx, vy, sfx, sfy, tx, ty;
      logic [31:0] pxx, pyy, pxy, pyx;
      bit active;
      vel_pair_t e;
      cx = longint'($signed(d[17:0]));
      cy = longint'($signed(d[35:18]));
      vx = longint'($signed(d[54:36]));
      vy = longint'($signed(d[73:55]));
      sfx = rev ? -longint'(fx) : longint'(fx);
      sfy = rev ? -longint'(fy) : longint'(fy);
      pxx = to_phase(sfx * cx);
      pyy = to_phase(sfy * cy);
      pxy = to_phase(sfx * cy);
      pyx = to_phase(sfy * cx);
      active = 1'b1;
      tx = 0;
      ty = 0;
      case (mode)
        MODE_SIN_RECT: begin tx = sin_of(pxx); ty = sin_of(pyy); end
        MODE_COS_RECT: begin tx = cos_of(pxx); ty = cos_of(pyy); end
        MODE_SIN_CURL: begin tx = sin_of(pyy); ty = sin_of(pxx); end
        MODE_COS_CURL: begin tx = cos_of(pyy); ty = cos_of(pxx); end
        MODE_SINCOS:   begin tx = sin_of(pxy); ty = cos_of(pyx); end
        MODE_COSSIN:   begin tx = cos_of(pyy); ty = sin_of(pxx); end
        MODE_SINTAN: begin
          tx = sin_of(tan_of(pyy));
          ty = cos_of(tan_of(pxx));
        end
        MODE_COSTAN: begin
          tx = cos_of(tan_of(pyy));
          ty = sin_of(tan_of(pxx));
        end
        MODE_SINOFCOS: begin
          tx = sin_of(pi_of(cos_of(pyy)));
          ty = cos_of(pi_of(sin_of(pxx)));
        end
        MODE_COSOFSIN: begin
          tx = cos_of(pi_of(sin_of(pyy)));
          ty = sin_of(pi_of(cos_of(pxx)));
        end
        default: active = 1'b0;
      endcase
      e.vx = add_sat(vx, tx, ax, active);
      e.vy = add_sat(vy, ty, ay, active);
      pending_q.push_back(e);
    endfunction

    task report_mismatch(string what, logic [VEL_W-1:0] got, logic [VEL_W-1:0] want);
      $display("MISMATCH %s: got %0d expected %0d (result %0d)", what, $signed(got),
               $signed(want), checked);
      mismatches++;
    endtask

    task check_result(logic [OUT_DATA_W-1:0] d);
      vel_pair_t e;
      if (pending_q.size() == 0) begin
        report_mismatch("unexpected output transaction", d[18:0], 19'd0);
      end else begin
        e = pending_q.pop_front();
        if (d[18:0] !== e.vx) report_mismatch("new_vel_x", d[18:0], e.vx);
        if (d[37:19] !== e.vy) report_mismatch("new_vel_y", d[37:19], e.vy);
      end
      checked++;
    endtask
  endclass

  logic                   clk_i = 1'b0;
  logic                   rst_ni = 1'b0;
  logic                   cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0]   cfg_idx_i = '0;
  logic [CFG_DATA_W-1:0]  cfg_data_i = '0;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [IN_DATA_W-1:0]   s_axis_tdata = '0;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic [OUT_DATA_W-1:0]  m_axis_tdata;

  displacement_scoreboard sb = new();
  bit          bursts_on = 1'b1;
  bit          hold_req  = 1'b0;
  int unsigned cycles    = 0;
  int unsigned sent      = 0;

  always #5 clk_i = ~clk_i;

  trig_velocity_displacement dut (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata
  );

  always @(posedge clk_i) begin
    if (rst_ni && s_axis_tvalid && s_axis_tready) sb.note_input(s_axis_tdata);
    if (rst_ni && m_axis_tvalid && m_axis_tready) sb.check_result(m_axis_tdata);
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("end of test: mismatches");
      $finish;
    end
  end

  // Output side: random stall bursts, plus one long hold on request.
  initial begin
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        m_axis_tready <= 1'b0;
        repeat (HOLD_CYCLES - 1) @(posedge clk_i);
        hold_req = 1'b0;
      end else if (bursts_on && $urandom_range(0, 5) == 0) begin
        m_axis_tready <= 1'b0;
        repeat ($urandom_range(0, 9)) @(posedge clk_i);
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  // The write enable stays high across back-to-back writes; callers drop it.
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    sb.write_reg(idx, val);
  endtask

  task automatic apply_cfg(disp_cfg_t c);
    write_reg(REG_EFFECT_MODE, c.mode);
    write_reg(REG_REVERSE_FREQ, c.rev);
    write_reg(REG_FREQ_X, c.fx);
    write_reg(REG_FREQ_Y, c.fy);
    write_reg(REG_AMP_X, c.ax);
    write_reg(REG_AMP_Y, c.ay);
    cfg_we_i <= 1'b0;
  endtask

  task automatic send_point(logic [17:0] cx, logic [17:0] cy, logic [18:0] vx,
                            logic [18:0] vy);
    if (bursts_on && $urandom_range(0, 5) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {6'b0, vy, vx, cy, cx};
    do @(posedge clk_i); while (!s_axis_tready);
    sent++;
  endtask

  function automatic logic [17:0] rand_coord();
    case ($urandom_range(0, 9))
      0:       return 18'h1FFFF;
      1:       return 18'h20000;
      2:       return 18'h0;
      default: return 18'($urandom);
    endcase
  endfunction

  function automatic logic [18:0] rand_vel();
    case ($urandom_range(0, 9))
      0:       return 19'h3FFFF;
      1:       return 19'h40000;
      default: return 19'($urandom);
    endcase
  endfunction

  task automatic send_random(int n);
    repeat (n) send_point(rand_coord(), rand_coord(), rand_vel(), rand_vel());
  endtask

  // Field extremes, with velocities at the rails.
  task automatic send_extremes();
    send_point(18'h0, 18'h0, 19'h0, 19'h0);
    send_point(18'h1FFFF, 18'h20000, 19'h3FFFF, 19'h40000);
    send_point(18'h20000, 18'h1FFFF, 19'h40000, 19'h3FFFF);
    send_point(18'h3FFFF, 18'h00001, 19'h7FFFF, 19'h00001);
    send_point(18'h2AAAA, 18'h15555, 19'h2AAAA, 19'h55555);
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (sb.pending_q.size() != 0) @(posedge clk_i);
    repeat (PIPE_LAT + 20) @(posedge clk_i);
  endtask

  disp_cfg_t phases[$];

  initial begin
    phases = '{
      '{MODE_SIN_RECT, 0, 2560, 2560, 139810, 139810},
      '{MODE_COS_RECT, 1, 0, 2560000, 1413120, 0},
      '{MODE_SIN_CURL, 0, 22'h3FFFFF, 300, 1413120, 1413120},
      '{MODE_COS_CURL, 1, 2560000, 0, 22'h1FFFFF, 1413120},
      '{MODE_SINCOS, 0, 777, 1234, 700000, 900000},
      '{MODE_COSSIN, 1, 50000, 256, 1413120, 1413120},
      '{MODE_SINTAN, 0, 256, 256, 1413120, 1413120},
      '{MODE_COSTAN, 1, 90000, 12345, 500000, 1413120},
      '{MODE_SINOFCOS, 0, 2560, 5000, 1413120, 1413120},
      '{MODE_COSOFSIN, 1, 2560000, 2560000, 1413120, 1413120},
      '{MODE_UNUSED_LO, 0, 2560, 2560, 1413120, 1413120},
      '{MODE_UNUSED_HI, 1, 2560, 2560, 1413120, 1413120},
      // Upper bits beyond each register's width must be dropped.
      '{22'h3FFFF3, 22'h3FFFFE, 2560, 9000, 22'h3FFFFF, 22'h2AAAAA},
      '{MODE_SINTAN, 1, 2560000, 2560000, 1413120, 1413120},
      '{MODE_COSOFSIN, 0, 30000, 700, 1413120, 1413120}
    };
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset settings: no displacement, velocities pass through.
    send_extremes();
    send_random(20);
    drain();
    write_reg(REG_UNMAPPED, 22'h3FFFFF);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);

    foreach (phases[p]) begin
      apply_cfg(phases[p]);
      if (p == phases.size() - 2) bursts_on = 1'b0;
      if (p == 6) begin
        // Angles just off a quarter turn drive tan into its limit.
        send_point(18'd102944, 18'd102944, 19'd0, 19'd0);
        send_point(-18'sd102944, 18'd102945, 19'd100, 19'd0);
        send_point(18'd102943, -18'sd102944, 19'd0, 19'd7);
      end
      if (p == 4) begin
        hold_req = 1'b1;
        send_random(HOLD_CYCLES / 2);
      end
      send_random(p == 1 ? 40 : 46);
      drain();
    end

    $display("%0d points sent, %0d results checked over %0d register settings",
             sent, sb.checked, phases.size() + 1);
    $display("all effect modes, unused modes, reversed frequencies and saturation covered");
    if (sb.mismatches == 0 && sb.pending_q.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
